>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> design/rtcf_pkg.sv
package rtcf_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } rtcf_state_e;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  localparam logic [1:0] CH_LAST  = 2'd2;
  localparam logic [2:0] BIT_LAST = 3'd7;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  function automatic logic [7:0] chan(input logic [23:0] color, input logic [1:0] idx);
    logic [7:0] res;
    unique case (idx)
      2'd0:    res = color[23:16];
      2'd1:    res = color[15:8];
      default: res = color[7:0];
    endcase
    return res;
  endfunction

endpackage

>>> design/rgb_timed_color_fader.sv
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | action_i, red_in_i, green_in_i, blue_in_i, fade_ticks_i
// out     | out_valid_o/ out_ready_i| red_out_o, green_out_o, blue_out_o, finished_o
//
// A set item is taken in ST_IDLE; a jump then loads the result from ST_EMIT.
// A tick that ends a fade goes straight to ST_EMIT; an intermediate tick first runs,
// per channel, one multiply in ST_MUL and 8 restoring-divide steps in ST_DIV in one shared unit.
// Reset clears the displayed, start and goal colors and stops any fade.
// A result waits in the output register; a new item is taken meanwhile, and the
// sequencer stalls only when it must load a second result before the first leaves.
module rgb_timed_color_fader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [15:0] fade_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        finished_o
);

  rtcf_pkg::rtcf_state_e state_q, state_d;

  logic [23:0] shown_q, shown_d;
  logic [23:0] start_q, start_d;
  logic [23:0] goal_q, goal_d;
  logic [23:0] next_q, next_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] len_q, len_d;
  logic        fading_q, fading_d;
  logic        fin_q, fin_d;
  logic [1:0]  ch_q, ch_d;
  logic [2:0]  bit_q, bit_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  quo_q, quo_d;

  logic        out_valid_q;
  logic [23:0] out_color_q;
  logic        out_fin_q;

  logic        in_fire;
  logic        out_free;
  logic [15:0] elapsed_inc;
  logic        fade_done;
  logic [7:0]  s_cur, g_cur, diff;
  logic        neg;
  logic [23:0] prod;
  logic [16:0] trial;
  logic        fits;
  logic [7:0]  quo_next;
  logic [7:0]  res;

  assign in_ready_o = (state_q == rtcf_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign elapsed_inc = (elapsed_q == rtcf_pkg::TICKS_MAX) ? elapsed_q : elapsed_q + 16'd1;
  assign fade_done   = (len_q == 16'd0) || (elapsed_inc >= len_q);

  assign s_cur = rtcf_pkg::chan(start_q, ch_q);
  assign g_cur = rtcf_pkg::chan(goal_q, ch_q);
  assign neg   = (g_cur < s_cur);
  assign diff  = neg ? (s_cur - g_cur) : (g_cur - s_cur);
  assign prod  = {16'd0, diff} * {8'd0, elapsed_q};

  assign trial    = {rem_q, low_q[7]};
  assign fits     = (trial >= {1'b0, len_q});
  assign quo_next = {quo_q[6:0], fits};
  assign res      = neg ? (s_cur - quo_next) : (s_cur + quo_next);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtcf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (action_i == rtcf_pkg::ACT_SET) begin
            if (fade_ticks_i == 16'd0) begin
              state_d = rtcf_pkg::ST_EMIT;
            end
          end else if (fading_q) begin
            state_d = fade_done ? rtcf_pkg::ST_EMIT : rtcf_pkg::ST_MUL;
          end
        end
      end
      rtcf_pkg::ST_MUL: state_d = rtcf_pkg::ST_DIV;
      rtcf_pkg::ST_DIV: begin
        if (bit_q == rtcf_pkg::BIT_LAST) begin
          state_d = (ch_q == rtcf_pkg::CH_LAST) ? rtcf_pkg::ST_EMIT : rtcf_pkg::ST_MUL;
        end
      end
      rtcf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = rtcf_pkg::ST_IDLE;
        end
      end
      default: state_d = rtcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    shown_d   = shown_q;
    start_d   = start_q;
    goal_d    = goal_q;
    next_d    = next_q;
    elapsed_d = elapsed_q;
    len_d     = len_q;
    fading_d  = fading_q;
    fin_d     = fin_q;
    ch_d      = ch_q;
    bit_d     = bit_q;
    rem_d     = rem_q;
    low_d     = low_q;
    quo_d     = quo_q;
    unique case (state_q)
      rtcf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (action_i == rtcf_pkg::ACT_SET) begin
            goal_d = {red_in_i, green_in_i, blue_in_i};
            if (fade_ticks_i == 16'd0) begin
              shown_d  = {red_in_i, green_in_i, blue_in_i};
              fading_d = 1'b0;
              fin_d    = 1'b1;
            end else begin
              start_d   = shown_q;
              len_d     = fade_ticks_i;
              elapsed_d = 16'd0;
              fading_d  = 1'b1;
            end
          end else if (fading_q) begin
            elapsed_d = elapsed_inc;
            if (fade_done) begin
              shown_d  = goal_q;
              fading_d = 1'b0;
              fin_d    = 1'b1;
            end else begin
              fin_d = 1'b0;
              ch_d  = 2'd0;
            end
          end
        end
      end
      rtcf_pkg::ST_MUL: begin
        rem_d = prod[23:8];
        low_d = prod[7:0];
        quo_d = 8'd0;
        bit_d = 3'd0;
      end
      rtcf_pkg::ST_DIV: begin
        rem_d = fits ? 16'(trial - {1'b0, len_q}) : trial[15:0];
        low_d = {low_q[6:0], 1'b0};
        quo_d = quo_next;
        bit_d = bit_q + 3'd1;
        if (bit_q == rtcf_pkg::BIT_LAST) begin
          next_d = {next_q[15:0], res};
          ch_d   = ch_q + 2'd1;
          if (ch_q == rtcf_pkg::CH_LAST) begin
            shown_d = {next_q[15:0], res};
          end
        end
      end
      rtcf_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtcf_pkg::ST_IDLE;
      shown_q     <= 24'd0;
      start_q     <= 24'd0;
      goal_q      <= 24'd0;
      elapsed_q   <= 16'd0;
      len_q       <= 16'd0;
      fading_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      shown_q   <= shown_d;
      start_q   <= start_d;
      goal_q    <= goal_d;
      elapsed_q <= elapsed_d;
      len_q     <= len_d;
      fading_q  <= fading_d;
      if (state_q == rtcf_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    fin_q  <= fin_d;
    ch_q   <= ch_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
    if (state_q == rtcf_pkg::ST_EMIT && out_free) begin
      out_color_q <= shown_q;
      out_fin_q   <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_color_q[23:16];
  assign green_out_o = out_color_q[15:8];
  assign blue_out_o  = out_color_q[7:0];
  assign finished_o  = out_fin_q;

endmodule

>>> design/rtcf_checker.sv
`include "assert_macros.svh"

module rtcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic [7:0]  red_in_i,
  input logic [7:0]  green_in_i,
  input logic [7:0]  blue_in_i,
  input logic [15:0] fade_ticks_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_out_o,
  input logic [7:0]  green_out_o,
  input logic [7:0]  blue_out_o,
  input logic        finished_o
);

  logic in_fire;
  logic jump;
  logic arm;

  assign in_fire = in_valid_i && in_ready_o;
  assign jump    = in_fire && (action_i == rtcf_pkg::ACT_SET) && (fade_ticks_i == 16'd0);
  assign arm     = in_fire && (action_i == rtcf_pkg::ACT_SET) && (fade_ticks_i != 16'd0);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NXT(a_arm_stays_ready, clk_i, rst_ni, arm, in_ready_o)
  `ASSERT_NXT(a_jump_busy, clk_i, rst_ni, jump, !in_ready_o)
  `ASSERT_NXT(a_jump_result, clk_i, rst_ni, jump && !out_valid_o,
    ##1 (out_valid_o && finished_o && red_out_o == $past(red_in_i, 2)
         && green_out_o == $past(green_in_i, 2) && blue_out_o == $past(blue_in_i, 2)))

endmodule

bind rgb_timed_color_fader rtcf_checker u_rtcf_checker (.*);

>>> verif/tb_rgb_timed_color_fader.sv
module tb_rgb_timed_color_fader;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 850;
  localparam int CALM_ITEMS  = 100;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 64;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
  } fade_result_t;

  typedef struct packed {
    logic        act;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] ticks;
    logic        typed;
    logic        present;
    logic [7:0]  exp_red;
    logic [7:0]  exp_green;
    logic [7:0]  exp_blue;
    logic        exp_done;
  } dir_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        action_i     = rtcf_pkg::ACT_TICK;
  logic [7:0]  red_in_i     = '0;
  logic [7:0]  green_in_i   = '0;
  logic [7:0]  blue_in_i    = '0;
  logic [15:0] fade_ticks_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        finished_o;

  rgb_timed_color_fader u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .fade_ticks_i (fade_ticks_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .finished_o   (finished_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0] shown_rgb;
  logic [23:0] from_rgb;
  logic [23:0] goal_rgb;
  logic [15:0] steps_done;
  logic [15:0] steps_total;
  logic        fade_active;

  fade_result_t expected_colors[$];
  fade_result_t want;

  int errors       = 0;
  int cycles       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int jumps        = 0;
  int fade_steps   = 0;
  int fade_ends    = 0;
  int restarts     = 0;
  int stall_left   = 0;
  bit gaps_on      = 1'b0;
  bit stalls_on    = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_SET,  8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{rtcf_pkg::ACT_SET,  8'hff, 8'hff, 8'hff, 16'h0000, 1'b1, 1'b1, 8'hff, 8'hff, 8'hff, 1'b1},
    '{rtcf_pkg::ACT_SET,  8'h00, 8'h00, 8'h00, 16'h0004, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h5a, 8'ha5, 8'h3c, 16'h1234, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{rtcf_pkg::ACT_TICK, 8'hff, 8'hff, 8'hff, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_SET,  8'ha5, 8'h5a, 8'h0f, 16'h0001, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'ha5, 8'h5a, 8'h0f, 1'b1},
    '{rtcf_pkg::ACT_SET,  8'h00, 8'hff, 8'h80, 16'h0003, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_SET,  8'hff, 8'h00, 8'hff, 16'h0002, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'hff, 8'h00, 8'hff, 1'b1},
    '{rtcf_pkg::ACT_SET,  8'h12, 8'h34, 8'h56, 16'hffff, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_SET,  8'h80, 8'h80, 8'h80, 16'h0000, 1'b1, 1'b1, 8'h80, 8'h80, 8'h80, 1'b1},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_SET,  8'hff, 8'hff, 8'hff, 16'haaaa, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_SET,  8'h00, 8'h00, 8'h00, 16'h5555, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{rtcf_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}
  };

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] lerp_level(input logic [7:0] from_lvl, input logic [7:0] to_lvl,
                                            input logic [15:0] done_cnt,
                                            input logic [15:0] total_cnt);
    logic [31:0] span;
    logic [31:0] mag;
    if (to_lvl >= from_lvl) begin
      span = to_lvl - from_lvl;
      mag  = (span * done_cnt) / total_cnt;
      return from_lvl + mag[7:0];
    end
    span = from_lvl - to_lvl;
    mag  = (span * done_cnt) / total_cnt;
    return from_lvl - mag[7:0];
  endfunction

  task automatic predict_fade(input dir_row_t row, output logic made, output fade_result_t res);
    logic [23:0] target;
    target = {row.red, row.green, row.blue};
    made   = 1'b0;
    res    = '0;
    if (row.act == rtcf_pkg::ACT_SET) begin
      goal_rgb = target;
      if (row.ticks == 16'd0) begin
        shown_rgb   = target;
        fade_active = 1'b0;
        made        = 1'b1;
        res         = '{target[23:16], target[15:8], target[7:0], 1'b1};
        jumps++;
      end else begin
        if (fade_active) restarts++;
        from_rgb    = shown_rgb;
        steps_total = row.ticks;
        steps_done  = '0;
        fade_active = 1'b1;
      end
    end else if (fade_active) begin
      if (steps_done != rtcf_pkg::TICKS_MAX) steps_done++;
      made = 1'b1;
      if (steps_done >= steps_total) begin
        shown_rgb   = goal_rgb;
        fade_active = 1'b0;
        res         = '{goal_rgb[23:16], goal_rgb[15:8], goal_rgb[7:0], 1'b1};
        fade_ends++;
      end else begin
        shown_rgb[23:16] = lerp_level(from_rgb[23:16], goal_rgb[23:16], steps_done, steps_total);
        shown_rgb[15:8]  = lerp_level(from_rgb[15:8], goal_rgb[15:8], steps_done, steps_total);
        shown_rgb[7:0]   = lerp_level(from_rgb[7:0], goal_rgb[7:0], steps_done, steps_total);
        res = '{shown_rgb[23:16], shown_rgb[15:8], shown_rgb[7:0], 1'b0};
        fade_steps++;
      end
    end
  endtask

  task automatic push_item(input dir_row_t row);
    logic         made;
    fade_result_t res;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= row.act;
    red_in_i     <= row.red;
    green_in_i   <= row.green;
    blue_in_i    <= row.blue;
    fade_ticks_i <= row.ticks;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_fade(row, made, res);
    if (row.typed) begin
      made = row.present;
      res  = '{row.exp_red, row.exp_green, row.exp_blue, row.exp_done};
    end
    if (made) expected_colors.push_back(res);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic dir_row_t make_set(input logic [15:0] ticks);
    dir_row_t row;
    row       = '0;
    row.act   = rtcf_pkg::ACT_SET;
    row.red   = rand_level();
    row.green = rand_level();
    row.blue  = rand_level();
    row.ticks = ticks;
    return row;
  endfunction

  function automatic dir_row_t make_tick();
    dir_row_t row;
    row       = '0;
    row.act   = rtcf_pkg::ACT_TICK;
    row.red   = 8'($urandom);
    row.green = 8'($urandom);
    row.blue  = 8'($urandom);
    row.ticks = 16'($urandom);
    return row;
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_colors.size() == 0) begin
        report_err($sformatf("unexpected item %02h%02h%02h finished=%0b",
                             red_out_o, green_out_o, blue_out_o, finished_o));
      end else begin
        want = expected_colors.pop_front();
        results_seen++;
        if (red_out_o !== want.red)
          report_err($sformatf("red %02h, want %02h", red_out_o, want.red));
        if (green_out_o !== want.green)
          report_err($sformatf("green %02h, want %02h", green_out_o, want.green));
        if (blue_out_o !== want.blue)
          report_err($sformatf("blue %02h, want %02h", blue_out_o, want.blue));
        if (finished_o !== want.done)
          report_err($sformatf("finished %0b, want %0b", finished_o, want.done));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycles,
               expected_colors.size());
      $display("rgb_timed_color_fader: mismatch");
      $finish;
    end
  end

  initial begin
    int       kind;
    int       len;
    int       count;
    shown_rgb   = '0;
    from_rgb    = '0;
    goal_rgb    = '0;
    steps_done  = '0;
    steps_total = '0;
    fade_active = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) push_item(dir_rows[i]);

    while (items_sent < TOTAL_ITEMS) begin
      if (TOTAL_ITEMS - items_sent > CALM_ITEMS) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end else begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        count = $urandom_range(1, 3);
        repeat (count) push_item(make_tick());
      end else if (kind < 4) begin
        push_item(make_set(16'd0));
      end else if (kind == 4) begin
        push_item(make_set(16'($urandom_range(13, 65535))));
        count = $urandom_range(1, 4);
        repeat (count) push_item(make_tick());
      end else begin
        len = $urandom_range(1, 12);
        push_item(make_set(16'(len)));
        if ($urandom_range(0, 3) == 0) count = $urandom_range(1, len);
        else count = len + $urandom_range(0, 2);
        repeat (count) push_item(make_tick());
      end
    end
    in_valid_i <= 1'b0;

    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d items driven, %0d results checked", items_sent, results_seen);
    $display("%0d jumps, %0d fade steps, %0d fades completed, %0d fades restarted",
             jumps, fade_steps, fade_ends, restarts);
    if (errors == 0) begin
      $display("rgb_timed_color_fader: match");
    end else begin
      $display("rgb_timed_color_fader: mismatch");
    end
    $finish;
  end

endmodule
